// ----- src/kpe_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package kpe_pkg;

  // Field widths
  localparam int DIGIT_W    = 4;
  localparam int TICK_W     = 16;
  localparam int CODE_W     = 16;
  localparam int SHOWN_DIGS = CODE_W / DIGIT_W;

  // APB configuration port
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;
  localparam logic [TICK_W-1:0] TIMEOUT_RST = 16'd50000;
  localparam logic [TICK_W-1:0] TICK_MAX    = 16'hFFFF;

  // Register index taken from paddr[2]
  localparam logic REG_IDLE_TIMEOUT = 1'b0;

  // Key codes
  localparam logic [DIGIT_W-1:0] KEY_LAST_DIGIT = 4'd9;
  localparam logic [DIGIT_W-1:0] KEY_LOCK       = 4'd10;
  localparam logic [DIGIT_W-1:0] KEY_EDIT       = 4'd11;

  typedef enum logic [1:0] {
    OP_KEY  = 2'd0,
    OP_TICK = 2'd1,
    OP_LOAD = 2'd2
  } opcode_t;

  typedef enum logic [2:0] {
    ST_NONE    = 3'd0,
    ST_PENDING = 3'd1,
    ST_SUCCESS = 3'd2,
    ST_FAILURE = 3'd3,
    ST_LOCK    = 3'd4,
    ST_EDIT    = 3'd5
  } status_t;

  // One captured input item
  typedef struct packed {
    logic [1:0]         opcode;
    logic               mode;
    logic [DIGIT_W-1:0] key;
    logic [CODE_W-1:0]  load_code;
  } in_item_t;

endpackage

`default_nettype wire

// ----- src/kpe_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Input item channel
interface kpe_in_if import kpe_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [1:0]          opcode;
  logic                mode;
  logic [DIGIT_W-1:0]  key;
  logic [CODE_W-1:0]   load_code;

  modport source (output valid, opcode, mode, key, load_code, input ready);
  modport sink   (input valid, opcode, mode, key, load_code, output ready);
endinterface

// Result item channel
interface kpe_out_if import kpe_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [2:0]          status;
  logic [CODE_W-1:0]   stored_code;

  modport source (output valid, status, stored_code, input ready);
  modport sink   (input valid, status, stored_code, output ready);
endinterface

`default_nettype wire

// ----- src/kpe_cfg.sv -----
`timescale 1ns / 1ps
`default_nettype none

module kpe_cfg import kpe_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready,
  output logic      [TICK_W-1:0]     idle_timeout
);

  logic [TICK_W-1:0] timeout_r;
  logic [TICK_W-1:0] timeout_nxt;
  logic              wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  // Register write on the APB access phase
  always_comb begin
    timeout_nxt = timeout_r;
    if (wr_en && (paddr[2] == REG_IDLE_TIMEOUT)) begin
      timeout_nxt = pwdata[TICK_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RST;
    end else begin
      timeout_r <= timeout_nxt;
    end
  end

  // Read-back
  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_IDLE_TIMEOUT) begin
      prdata = APB_DATA_W'(timeout_r);
    end
  end

  assign idle_timeout = timeout_r;

endmodule

`default_nettype wire

// ----- src/kpe_in_stage.sv -----
`timescale 1ns / 1ps
`default_nettype none

module kpe_in_stage import kpe_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  kpe_in_if.sink        in_ch,
  input  wire logic     adv,       // core takes the held item this cycle if valid
  output logic          item_valid,
  output in_item_t      item
);

  logic     v_r;
  logic     v_nxt;
  in_item_t item_r;
  logic     take;

  // Room when empty or when the held item moves on
  assign in_ch.ready = !v_r || adv;
  assign take        = in_ch.valid && in_ch.ready;

  always_comb begin
    v_nxt = v_r;
    if (take) begin
      v_nxt = 1'b1;
    end else if (adv) begin
      v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  // Payload capture on transfer
  always_ff @(posedge clk) begin
    if (take) begin
      item_r.opcode    <= in_ch.opcode;
      item_r.mode      <= in_ch.mode;
      item_r.key       <= in_ch.key;
      item_r.load_code <= in_ch.load_code;
    end
  end

  assign item_valid = v_r;
  assign item       = item_r;

endmodule

`default_nettype wire

// ----- src/kpe_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

module kpe_core import kpe_pkg::*; #(
  parameter int CODE_DIGITS = 4
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              item_valid,
  input  wire in_item_t          item,
  output logic                   adv,
  input  wire logic [TICK_W-1:0] idle_timeout,
  kpe_out_if.source              out_ch
);

  localparam int CNT_W  = $clog2(CODE_DIGITS + 1);
  localparam int WIDE_W = DIGIT_W * ((CODE_DIGITS > SHOWN_DIGS) ? CODE_DIGITS : SHOWN_DIGS);
  localparam logic [CNT_W-1:0] LAST_POS = CNT_W'(CODE_DIGITS - 1);

  logic [DIGIT_W-1:0] store_r   [CODE_DIGITS];
  logic [DIGIT_W-1:0] store_nxt [CODE_DIGITS];
  logic [DIGIT_W-1:0] chk_r     [CODE_DIGITS];
  logic [DIGIT_W-1:0] chk_nxt   [CODE_DIGITS];
  logic [DIGIT_W-1:0] new_r     [CODE_DIGITS];
  logic [DIGIT_W-1:0] new_nxt   [CODE_DIGITS];
  logic [DIGIT_W-1:0] cand      [CODE_DIGITS];
  logic [CNT_W-1:0]   chk_cnt_r, chk_cnt_nxt;
  logic [CNT_W-1:0]   new_cnt_r, new_cnt_nxt;
  logic [CNT_W-1:0]   cur_cnt;
  logic [TICK_W-1:0]  ticks_r, ticks_nxt, ticks_inc;
  logic               out_v_r, out_v_nxt;
  status_t            status_r, status_nxt;
  logic [CODE_W-1:0]  code_out_r, code_out_nxt;
  logic [WIDE_W-1:0]  load_wide;
  logic [WIDE_W-1:0]  store_wide;
  logic               fire;
  logic               match;

  // Work on the held item whenever the result register is free
  assign adv  = !out_v_r || out_ch.ready;
  assign fire = item_valid && adv;

  assign cur_cnt   = item.mode ? new_cnt_r : chk_cnt_r;
  assign ticks_inc = (ticks_r == TICK_MAX) ? ticks_r : ticks_r + 1'b1;
  assign load_wide = WIDE_W'(item.load_code);

  // Buffer as it would be with the pressed digit placed
  always_comb begin
    for (int i = 0; i < CODE_DIGITS; i++) begin
      cand[i] = item.mode ? new_r[i] : chk_r[i];
      if (cur_cnt == CNT_W'(i)) begin
        cand[i] = item.key;
      end
    end
  end

  always_comb begin
    match = 1'b1;
    for (int i = 0; i < CODE_DIGITS; i++) begin
      if (cand[i] != store_r[i]) begin
        match = 1'b0;
      end
    end
  end

  // Item decode and state update
  always_comb begin
    store_nxt   = store_r;
    chk_nxt     = chk_r;
    new_nxt     = new_r;
    chk_cnt_nxt = chk_cnt_r;
    new_cnt_nxt = new_cnt_r;
    ticks_nxt   = ticks_r;
    status_nxt  = ST_NONE;
    case (item.opcode)
      OP_KEY: begin
        if (item.key == KEY_LOCK || item.key == KEY_EDIT) begin
          ticks_nxt  = '0;
          status_nxt = (item.key == KEY_LOCK) ? ST_LOCK : ST_EDIT;
          if (item.mode) begin
            new_cnt_nxt = '0;
          end else begin
            chk_cnt_nxt = '0;
          end
        end else if (item.key <= KEY_LAST_DIGIT) begin
          ticks_nxt = '0;
          if (cur_cnt != LAST_POS) begin
            status_nxt = ST_PENDING;
            if (item.mode) begin
              new_nxt     = cand;
              new_cnt_nxt = new_cnt_r + 1'b1;
            end else begin
              chk_nxt     = cand;
              chk_cnt_nxt = chk_cnt_r + 1'b1;
            end
          end else if (item.mode) begin
            store_nxt   = cand;
            new_cnt_nxt = '0;
            status_nxt  = ST_SUCCESS;
          end else begin
            chk_cnt_nxt = '0;
            status_nxt  = match ? ST_SUCCESS : ST_FAILURE;
          end
        end
      end
      OP_TICK: begin
        ticks_nxt = ticks_inc;
        if (ticks_inc > idle_timeout) begin
          ticks_nxt  = '0;
          status_nxt = ST_FAILURE;
          if (item.mode) begin
            new_cnt_nxt = '0;
          end else begin
            chk_cnt_nxt = '0;
          end
        end
      end
      OP_LOAD: begin
        for (int i = 0; i < CODE_DIGITS; i++) begin
          store_nxt[i] = load_wide[DIGIT_W*i +: DIGIT_W];
        end
      end
      default: begin
        status_nxt = ST_NONE;
      end
    endcase
  end

  // Pack the first shown digits of the updated store
  always_comb begin
    store_wide = '0;
    for (int i = 0; i < CODE_DIGITS; i++) begin
      store_wide[DIGIT_W*i +: DIGIT_W] = store_nxt[i];
    end
    code_out_nxt = store_wide[CODE_W-1:0];
  end

  always_comb begin
    out_v_nxt = out_v_r;
    if (fire) begin
      out_v_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_v_nxt = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r   <= 1'b0;
      chk_cnt_r <= '0;
      new_cnt_r <= '0;
      ticks_r   <= '0;
      for (int i = 0; i < CODE_DIGITS; i++) begin
        store_r[i] <= '0;
        chk_r[i]   <= '0;
        new_r[i]   <= '0;
      end
    end else begin
      out_v_r <= out_v_nxt;
      if (fire) begin
        chk_cnt_r <= chk_cnt_nxt;
        new_cnt_r <= new_cnt_nxt;
        ticks_r   <= ticks_nxt;
        store_r   <= store_nxt;
        chk_r     <= chk_nxt;
        new_r     <= new_nxt;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (fire) begin
      status_r   <= status_nxt;
      code_out_r <= code_out_nxt;
    end
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.status      = status_r;
  assign out_ch.stored_code = code_out_r;

  // A buffer is never left full: it clears on the completing digit
  a_chk_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    chk_cnt_r < CNT_W'(CODE_DIGITS))
    else $error("check count reached a full buffer");

  a_new_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    new_cnt_r < CNT_W'(CODE_DIGITS))
    else $error("set count reached a full buffer");

  // A stalled result is kept until taken
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_ch.ready |=> out_v_r && $stable(status_r) && $stable(code_out_r))
    else $error("stalled result changed");

  // Idle count only runs on ticks and clears on key activity
  a_ticks: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> $stable(ticks_r))
    else $error("idle count moved without an item");

endmodule

`default_nettype wire

// ----- src/keypad_passcode_entry.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel   Ports             Direction  Contents
// -------   ---------------   ---------  -----------------------------------------
// input     in_ch (sink)      in         opcode, mode, key, load_code
// result    out_ch (source)   out        status, stored_code
// config    cfg_p*            in/out     APB, idle_timeout at byte address 0
//
// Each item passes an input register and then combinational decode/update logic
// into the result register; one item per clock is sustained while out_ch.ready
// is high. State is updated only as the item moves into the result register,
// so the next item always sees it. A stalled result holds the input register;
// in_ch.ready follows out_ch.ready combinationally.
// rst_n is synchronous: stored code, buffers and idle count go to zero.

module keypad_passcode_entry import kpe_pkg::*; #(
  parameter int CODE_DIGITS = 4
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  kpe_in_if.sink                     in_ch,
  kpe_out_if.source                  out_ch,
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [APB_ADDR_W-1:0] cfg_paddr,
  input  wire logic [APB_DATA_W-1:0] cfg_pwdata,
  output logic      [APB_DATA_W-1:0] cfg_prdata,
  output logic                       cfg_pready
);

  logic              adv;
  logic              item_valid;
  in_item_t          item;
  logic [TICK_W-1:0] idle_timeout;

  kpe_cfg u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (cfg_psel),
    .penable      (cfg_penable),
    .pwrite       (cfg_pwrite),
    .paddr        (cfg_paddr),
    .pwdata       (cfg_pwdata),
    .prdata       (cfg_prdata),
    .pready       (cfg_pready),
    .idle_timeout (idle_timeout)
  );

  kpe_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .adv        (adv),
    .item_valid (item_valid),
    .item       (item)
  );

  kpe_core #(
    .CODE_DIGITS (CODE_DIGITS)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item         (item),
    .adv          (adv),
    .idle_timeout (idle_timeout),
    .out_ch       (out_ch)
  );

endmodule

`default_nettype wire
